>>> rtl/core/ipq_pkg.sv
// shared types and constants of the interrupt priority queue
`timescale 1ns / 1ps
package ipq_pkg;

   localparam int unsigned TASK_W = 2;
   localparam int unsigned PRIO_W = 3;

   // task codes
   localparam logic [TASK_W-1:0] TASK_TIMER = 2'd0;
   localparam logic [TASK_W-1:0] TASK_RX    = 2'd1;
   localparam logic [TASK_W-1:0] TASK_TX    = 2'd2;

   // request action codes
   localparam logic ACT_ARRIVE = 1'b0;
   localparam logic ACT_DONE   = 1'b1;

   // status bit positions
   localparam int unsigned CORE_TIMER_BIT = 1;
   localparam int unsigned IDENT_RX_BIT   = 2;
   localparam int unsigned IDENT_TX_BIT   = 1;

   // register indexes
   localparam logic CSR_TIMER_PRIO = 1'b0;
   localparam logic CSR_UART_PRIO  = 1'b1;

   localparam logic [PRIO_W-1:0] TIMER_PRIO_RESET = 3'd1;
   localparam logic [PRIO_W-1:0] UART_PRIO_RESET  = 3'd3;

   typedef struct packed {
      logic       action;
      logic [7:0] core_source;
      logic       aux_pending;
      logic [7:0] uart_ident;
   } req_type;

   typedef struct packed {
      logic              head_valid;
      logic [TASK_W-1:0] head_task;
      logic              mask_timer;
      logic              clear_receive;
      logic              clear_transmit;
      logic [3:0]        pending_count;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // outcome of classifying one arrival
   typedef struct packed {
      logic      have;
      logic      mask_timer;
      logic      clear_receive;
      logic      clear_transmit;
      entry_type entry;
   } class_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type new_entry;
   } ctrl_type;

endpackage

>>> rtl/core/ipq_classify.sv
// source classification with fixed precedence: timer, uart receive, uart transmit
`timescale 1ns / 1ps
module ipq_classify (
   input  ipq_pkg::req_type              req,
   input  logic [ipq_pkg::PRIO_W-1:0]    timer_prio,
   input  logic [ipq_pkg::PRIO_W-1:0]    uart_prio,
   output ipq_pkg::class_type            cls
);

   always_comb begin
      cls = '0;
      priority if (req.core_source[ipq_pkg::CORE_TIMER_BIT]) begin
         cls.have          = 1'b1;
         cls.mask_timer    = 1'b1;
         cls.entry.task_id = ipq_pkg::TASK_TIMER;
         cls.entry.prio    = timer_prio;
      end else if (req.aux_pending && req.uart_ident[ipq_pkg::IDENT_RX_BIT]) begin
         cls.have          = 1'b1;
         cls.clear_receive = 1'b1;
         cls.entry.task_id = ipq_pkg::TASK_RX;
         cls.entry.prio    = uart_prio;
      end else if (req.aux_pending && req.uart_ident[ipq_pkg::IDENT_TX_BIT]) begin
         cls.have           = 1'b1;
         cls.clear_transmit = 1'b1;
         cls.entry.task_id  = ipq_pkg::TASK_TX;
         cls.entry.prio     = uart_prio;
      end else begin
         cls = '0;
      end
   end

endmodule

>>> rtl/core/ipq_cell.sv
// one queue slot: compares against the new task and shifts with its neighbors
`timescale 1ns / 1ps
module ipq_cell (
   input  logic                clock,
   input  ipq_pkg::ctrl_type   ctrl,
   input  logic                occupied,
   input  logic                left_after,
   input  ipq_pkg::entry_type  left_entry,
   input  ipq_pkg::entry_type  right_entry,
   output ipq_pkg::entry_type  entry_out,
   output logic                after_out
);

   ipq_pkg::entry_type entry_ff;
   ipq_pkg::entry_type entry_in;

   // new task goes behind this slot
   assign after_out = occupied && (entry_ff.prio <= ctrl.new_entry.prio);
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert) begin
         priority if (!left_after) entry_in = left_entry;
         else if (!after_out)      entry_in = ctrl.new_entry;
         else                      entry_in = entry_ff;
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/core/irq_priority_event_queue_top.sv
// top level of the interrupt priority queue: cell chain, count and response
`timescale 1ns / 1ps
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ---------------------------
//  request   start, busy, req_payload                taken when start && !busy
//  response  rsp_valid, rsp_payload                  one-cycle strobe, no stall
//  csr       csr_we, csr_index, csr_wdata            write when csr_we
//
//  a request updates the cell chain at the accepting edge and the response is
//  shown in the following cycle while busy is high
//  each cell decides insert, shift or hold from a compare with its own
//  priority and its left neighbor's compare
//  synchronous reset empties the queue and restores the default priorities
//  the receiver cannot stall, so busy is high only during the response cycle
//
module irq_priority_event_queue_top #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  ipq_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   output ipq_pkg::rsp_type             rsp_payload,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [ipq_pkg::PRIO_W-1:0]   csr_wdata
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   // priority registers
   logic [ipq_pkg::PRIO_W-1:0] timer_prio_ff;
   logic [ipq_pkg::PRIO_W-1:0] uart_prio_ff;

   // queue occupancy
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // response strobe and pulses
   logic rsp_valid_ff;
   logic mask_timer_ff;
   logic clear_rx_ff;
   logic clear_tx_ff;
   logic overflow_ff;
   logic mask_timer_in;
   logic clear_rx_in;
   logic clear_tx_in;
   logic overflow_in;

   logic               accept;
   logic               full;
   ipq_pkg::class_type cls;
   ipq_pkg::ctrl_type  ctrl;

   ipq_pkg::entry_type cell_entry [QUEUE_DEPTH];
   logic               cell_after [QUEUE_DEPTH];
   logic               cell_occupied [QUEUE_DEPTH];

   logic [CNT_W+3:0]   count_wide;

   assign accept = start && !rsp_valid_ff;
   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));

   ipq_classify u_classify (
      .req        (req_payload),
      .timer_prio (timer_prio_ff),
      .uart_prio  (uart_prio_ff),
      .cls        (cls)
   );

   // command for the cell chain
   always_comb begin
      ctrl.new_entry = cls.entry;
      ctrl.insert    = accept && (req_payload.action == ipq_pkg::ACT_ARRIVE)
                       && cls.have && !full;
      ctrl.remove    = accept && (req_payload.action == ipq_pkg::ACT_DONE)
                       && (count_ff != '0);
   end

   // the chain of slots, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      ipq_pkg::entry_type left_entry;
      ipq_pkg::entry_type right_entry;
      logic               left_after;

      assign cell_occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         // nothing sits ahead of the head slot
         assign left_entry = '0;
         assign left_after = 1'b1;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
         assign left_after = cell_after[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      ipq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (cell_occupied[i]),
         .left_after  (left_after),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry_out   (cell_entry[i]),
         .after_out   (cell_after[i])
      );
   end

   // count and pulse next values
   always_comb begin
      count_in      = count_ff;
      mask_timer_in = 1'b0;
      clear_rx_in   = 1'b0;
      clear_tx_in   = 1'b0;
      overflow_in   = 1'b0;
      if (ctrl.insert) count_in = count_ff + 1'b1;
      if (ctrl.remove) count_in = count_ff - 1'b1;
      if (accept && (req_payload.action == ipq_pkg::ACT_ARRIVE)) begin
         // source is acknowledged even when the task is dropped
         mask_timer_in = cls.mask_timer;
         clear_rx_in   = cls.clear_receive;
         clear_tx_in   = cls.clear_transmit;
         overflow_in   = cls.have && full;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         timer_prio_ff <= ipq_pkg::TIMER_PRIO_RESET;
         uart_prio_ff  <= ipq_pkg::UART_PRIO_RESET;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         if (csr_we) begin
            unique case (csr_index)
               ipq_pkg::CSR_TIMER_PRIO: timer_prio_ff <= csr_wdata;
               ipq_pkg::CSR_UART_PRIO:  uart_prio_ff  <= csr_wdata;
               default:                 timer_prio_ff <= timer_prio_ff;
            endcase
         end
      end
   end

   // pulse registers, only looked at with the strobe
   always_ff @(posedge clock) begin
      mask_timer_ff <= mask_timer_in;
      clear_rx_ff   <= clear_rx_in;
      clear_tx_ff   <= clear_tx_in;
      overflow_ff   <= overflow_in;
   end

   // response: head read live from slot 0, stable while busy
   assign count_wide = {4'b0000, count_ff};

   always_comb begin
      rsp_payload.head_valid     = (count_ff != '0);
      rsp_payload.head_task      = (count_ff != '0) ? cell_entry[0].task_id
                                                    : ipq_pkg::TASK_TIMER;
      rsp_payload.mask_timer     = mask_timer_ff;
      rsp_payload.clear_receive  = clear_rx_ff;
      rsp_payload.clear_transmit = clear_tx_ff;
      rsp_payload.pending_count  = count_wide[3:0];
      rsp_payload.overflow       = overflow_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign busy      = rsp_valid_ff;

   // every accepted request gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted request without response");

   // responses never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held two cycles");

   // overflow only when the queue is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.overflow) |-> (count_ff == CNT_W'(QUEUE_DEPTH)))
      else $error("overflow reported on a queue with room");

   // at most one source acknowledged per request
   a_one_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_payload.mask_timer, rsp_payload.clear_receive,
                              rsp_payload.clear_transmit}))
      else $error("more than one acknowledge pulse");

   // occupancy never exceeds the slot count
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule
